FILE: rtl/tvrs_pkg.sv
// Shared types, widths and constants of the truth versus reco sum anomaly monitor.
package tvrs_pkg;

   localparam int EnergyW  = 24;
   localparam int MomW     = 24;
   localparam int MomThrW  = 25;
   localparam int Q12W     = 16;
   localparam int LevelW   = 17;
   localparam int IntervW  = 16;
   localparam int ESumW    = 34;
   localparam int PSumW    = 35;
   localparam int SqW      = 48;
   localparam int RootW    = 24;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 25;

   localparam int DefMaxParticles = 1024;

   typedef enum logic [1:0] {
      OP_TRUTH = 2'd0,
      OP_RECO  = 2'd1,
      OP_END   = 2'd2,
      OP_NONE  = 2'd3
   } tvrs_op_type;

   localparam logic [CsrIdxW-1:0] CSR_ENERGY_THR = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_MOM_THR    = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_MAX_ANOM   = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_INTERVAL   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_ALERT_LVL  = 3'd4;

   localparam logic [Q12W-1:0]    MAX_ANOM_RESET  = 16'd4096;
   localparam logic [IntervW-1:0] INTERVAL_RESET  = 16'd1;
   localparam logic [LevelW-1:0]  ALERT_LVL_RESET = 17'd6554;
   localparam logic [LevelW-1:0]  LEVEL_ONE       = 17'd65536;

   typedef struct packed {
      logic [EnergyW-1:0] energy_cut;
      logic [MomThrW-1:0] mom_cut;
      logic [Q12W-1:0]    max_anomaly;
      logic [IntervW-1:0] report_interval;
      logic [LevelW-1:0]  alert_level;
   } tvrs_cfg_type;

   typedef struct packed {
      tvrs_op_type        op;
      logic [EnergyW-1:0] energy;
      logic               e_ok;
      logic               p_ok;
      logic [SqW-1:0]     sq;
   } tvrs_item_type;

endpackage

FILE: rtl/tvrs_ifs.sv
// Handshake channel interfaces for particle items and anomaly results.
interface tvrs_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   op;
   logic [tvrs_pkg::EnergyW-1:0] particle_energy;
   logic [tvrs_pkg::MomW-1:0]    mom_x;
   logic [tvrs_pkg::MomW-1:0]    mom_y;
   logic [tvrs_pkg::MomW-1:0]    mom_z;
   modport source (output valid, op, particle_energy, mom_x, mom_y, mom_z, input ready);
   modport sink (input valid, op, particle_energy, mom_x, mom_y, mom_z, output ready);
endinterface

interface tvrs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tvrs_pkg::Q12W-1:0]   energy_dev;
   logic [tvrs_pkg::Q12W-1:0]   mom_dev;
   logic [tvrs_pkg::LevelW-1:0] anomaly_level;
   logic                        alert;
   modport source (output valid, energy_dev, mom_dev, anomaly_level, alert,
                   input ready);
   modport sink (input valid, energy_dev, mom_dev, anomaly_level, alert,
                 output ready);
endinterface

FILE: rtl/tvrs_front.sv
// Front end: takes items, squares the momentum and classifies against thresholds.
module tvrs_front (
   input  logic                    clock,
   input  logic                    reset,
   tvrs_req_if.sink                req_chan,
   input  tvrs_pkg::tvrs_cfg_type  cfg,
   output tvrs_pkg::tvrs_item_type push_item,
   output logic                    push_valid,
   input  logic                    push_full
);
   import tvrs_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_type;

   fstate_type         state_ff;
   logic [1:0]         step_ff;
   tvrs_op_type        op_ff;
   logic [EnergyW-1:0] energy_ff;
   logic [MomW-1:0]    ax_ff, ay_ff, az_ff;
   logic [2*MomThrW-1:0] prod_ff;
   logic [SqW-1:0]     sq_ff;

   logic [MomThrW-1:0]   mul_a;
   logic [2*MomThrW-1:0] prod_in;
   logic [MomW-1:0]      ax_in, ay_in, az_in;

   function automatic logic [MomW-1:0] mag(input logic [MomW-1:0] v);
      mag = v[MomW-1] ? (~v + MomW'(1)) : v;
   endfunction

   assign ax_in = mag(req_chan.mom_x);
   assign ay_in = mag(req_chan.mom_y);
   assign az_in = mag(req_chan.mom_z);

   // one shared multiplier: three squares, then the threshold squared
   always_comb begin
      case (step_ff)
         2'd0:    mul_a = {1'b0, ax_ff};
         2'd1:    mul_a = {1'b0, ay_ff};
         2'd2:    mul_a = {1'b0, az_ff};
         default: mul_a = cfg.mom_cut;
      endcase
      prod_in = mul_a * mul_a;
   end

   assign req_chan.ready   = (state_ff == F_IDLE);
   assign push_valid       = (state_ff == F_PUSH);
   assign push_item.op     = op_ff;
   assign push_item.energy = energy_ff;
   assign push_item.e_ok   = energy_ff > cfg.energy_cut;
   assign push_item.p_ok   = {2'b00, sq_ff} > prod_ff;
   assign push_item.sq     = sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= 2'd0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_chan.valid) begin
                  op_ff     <= tvrs_op_type'(req_chan.op);
                  energy_ff <= req_chan.particle_energy;
                  ax_ff     <= ax_in;
                  ay_ff     <= ay_in;
                  az_ff     <= az_in;
                  sq_ff     <= '0;
                  step_ff   <= 2'd0;
                  case (tvrs_op_type'(req_chan.op)) inside
                     OP_TRUTH, OP_RECO: state_ff <= F_MUL;
                     OP_END:            state_ff <= F_PUSH;
                     default:           state_ff <= F_IDLE;
                  endcase
               end
            end
            F_MUL: begin
               prod_ff <= prod_in;
               if (step_ff != 2'd0) sq_ff <= sq_ff + prod_ff[SqW-1:0];
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (!push_full) state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/tvrs_queue.sv
// Two-entry queue of classified items between front and back.
module tvrs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tvrs_pkg::tvrs_item_type wdata,
   output logic                    full,
   input  logic                    pop,
   output tvrs_pkg::tvrs_item_type rdata,
   output logic                    empty
);
   import tvrs_pkg::*;

   tvrs_item_type mem_ff [2];
   logic          wr_ff, rd_ff;
   logic [1:0]    count_ff;
   logic          do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= wdata;
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= ~wr_ff;
         if (do_pop)  rd_ff <= ~rd_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

FILE: rtl/tvrs_back.sv
// Back end: sums with saturation, square root loop, shared divider and result register.
module tvrs_back #(
   parameter int MAX_PARTICLES = tvrs_pkg::DefMaxParticles
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tvrs_pkg::tvrs_cfg_type  cfg,
   input  tvrs_pkg::tvrs_item_type item,
   input  logic                    item_valid,
   output logic                    pop,
   tvrs_rsp_if.source              rsp_chan
);
   import tvrs_pkg::*;

   localparam int CntW = $clog2(MAX_PARTICLES + 1);
   localparam logic [CntW-1:0] CntMax = CntW'(MAX_PARTICLES);

   typedef enum logic [2:0] {B_IDLE, B_SQRT, B_PREP, B_DIV, B_OUT} bstate_type;
   typedef enum logic [1:0] {P_E, P_M, P_L} phase_type;

   bstate_type          state_ff;
   phase_type           phase_ff;
   logic [ESumW-1:0]    te_ff, re_ff;
   logic [PSumW-1:0]    tp_ff, rp_ff;
   logic [CntW-1:0]     tcnt_ff, rcnt_ff;
   logic [IntervW-1:0]  evt_ff;
   logic                reco_ff;
   logic [SqW-1:0]      n_ff;
   logic [SqW:0]        root_ff, bit_ff;
   logic [PSumW-1:0]    r_ff, den_ff;
   logic [Q12W-1:0]     low_ff, q_ff;
   logic [3:0]          dstep_ff;
   logic [Q12W-1:0]     ea_ff, ma_ff;
   logic [LevelW-1:0]   lvl_ff;
   logic                rsp_valid_ff;
   logic [Q12W-1:0]     rsp_ea_ff, rsp_ma_ff;
   logic [LevelW-1:0]   rsp_lvl_ff;
   logic                rsp_alert_ff;

   logic                is_reco, cnt_full;
   logic [ESumW:0]      te_add, re_add;
   logic [ESumW-1:0]    te_in, re_in;
   logic [SqW:0]        trial, root_in;
   logic                take;
   logic [PSumW:0]      tp_add, rp_add;
   logic [PSumW-1:0]    tp_in, rp_in;
   logic [IntervW-1:0]  evt_in, interval;
   logic [PSumW-1:0]    dv_t, dv_r, dv_d;
   logic [LevelW-1:0]   s_sum, lim;
   logic [PSumW:0]      dv_trial;
   logic                dv_ge;
   logic [PSumW-1:0]    r_in;
   logic [Q12W-1:0]     q_in;
   logic                rsp_load;

   assign is_reco  = (item.op == OP_RECO);
   assign cnt_full = is_reco ? (rcnt_ff >= CntMax) : (tcnt_ff >= CntMax);

   assign te_add = {1'b0, te_ff} + (ESumW+1)'(item.energy);
   assign re_add = {1'b0, re_ff} + (ESumW+1)'(item.energy);
   assign te_in  = te_add[ESumW] ? '1 : te_add[ESumW-1:0];
   assign re_in  = re_add[ESumW] ? '1 : re_add[ESumW-1:0];

   // one step of the bit-pair square root
   assign trial   = root_ff + bit_ff;
   assign take    = {1'b0, n_ff} >= trial;
   assign root_in = take ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);

   assign tp_add = {1'b0, tp_ff} + (PSumW+1)'(root_in[RootW-1:0]);
   assign rp_add = {1'b0, rp_ff} + (PSumW+1)'(root_in[RootW-1:0]);
   assign tp_in  = tp_add[PSumW] ? '1 : tp_add[PSumW-1:0];
   assign rp_in  = rp_add[PSumW] ? '1 : rp_add[PSumW-1:0];

   assign evt_in   = evt_ff + IntervW'(1);
   assign interval = (cfg.report_interval == '0) ? IntervW'(1) : cfg.report_interval;

   assign dv_t  = (phase_ff == P_E) ? {1'b0, te_ff} : tp_ff;
   assign dv_r  = (phase_ff == P_E) ? {1'b0, re_ff} : rp_ff;
   assign dv_d  = (dv_r > dv_t) ? (dv_r - dv_t) : (dv_t - dv_r);
   assign s_sum = {1'b0, ea_ff} + {1'b0, ma_ff};
   assign lim   = (cfg.max_anomaly == '0) ? LevelW'(2) : {cfg.max_anomaly, 1'b0};

   // one restoring division step
   assign dv_trial = {r_ff, low_ff[Q12W-1]};
   assign dv_ge    = dv_trial >= {1'b0, den_ff};
   assign r_in     = dv_ge ? PSumW'(dv_trial - {1'b0, den_ff}) : dv_trial[PSumW-1:0];
   assign q_in     = {q_ff[Q12W-2:0], dv_ge};

   assign rsp_load = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   assign pop                    = (state_ff == B_IDLE) && item_valid;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.energy_dev    = rsp_ea_ff;
   assign rsp_chan.mom_dev       = rsp_ma_ff;
   assign rsp_chan.anomaly_level = rsp_lvl_ff;
   assign rsp_chan.alert         = rsp_alert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         phase_ff     <= P_E;
         te_ff        <= '0;
         re_ff        <= '0;
         tp_ff        <= '0;
         rp_ff        <= '0;
         tcnt_ff      <= '0;
         rcnt_ff      <= '0;
         evt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load)            rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (item_valid) begin
                  case (item.op) inside
                     OP_TRUTH, OP_RECO: begin
                        if (!cnt_full) begin
                           if (is_reco) begin
                              rcnt_ff <= rcnt_ff + CntW'(1);
                              if (item.e_ok) re_ff <= re_in;
                           end else begin
                              tcnt_ff <= tcnt_ff + CntW'(1);
                              if (item.e_ok) te_ff <= te_in;
                           end
                           if (item.p_ok) begin
                              reco_ff  <= is_reco;
                              n_ff     <= item.sq;
                              root_ff  <= '0;
                              bit_ff   <= (SqW+1)'(1) << (SqW - 2);
                              state_ff <= B_SQRT;
                           end
                        end
                     end
                     OP_END: begin
                        if (evt_in < interval) begin
                           evt_ff  <= evt_in;
                           te_ff   <= '0;
                           re_ff   <= '0;
                           tp_ff   <= '0;
                           rp_ff   <= '0;
                           tcnt_ff <= '0;
                           rcnt_ff <= '0;
                        end else begin
                           evt_ff   <= '0;
                           phase_ff <= P_E;
                           state_ff <= B_PREP;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            B_SQRT: begin
               if (take) n_ff <= n_ff - trial[SqW-1:0];
               root_ff <= root_in;
               bit_ff  <= bit_ff >> 2;
               if (bit_ff == (SqW+1)'(1)) begin
                  if (reco_ff) rp_ff <= rp_in;
                  else         tp_ff <= tp_in;
                  state_ff <= B_IDLE;
               end
            end
            B_PREP: begin
               q_ff     <= '0;
               dstep_ff <= '0;
               if (phase_ff == P_L) begin
                  if (s_sum >= lim) begin
                     lvl_ff   <= LEVEL_ONE;
                     state_ff <= B_OUT;
                  end else begin
                     r_ff     <= PSumW'(s_sum);
                     den_ff   <= PSumW'(lim);
                     low_ff   <= '0;
                     state_ff <= B_DIV;
                  end
               end else if (dv_t == '0 || {4'b0000, dv_d} >= {dv_t, 4'b0000}) begin
                  // zero truth gives zero, sixteen times or more saturates
                  if (phase_ff == P_E) begin
                     ea_ff    <= (dv_t == '0) ? '0 : '1;
                     phase_ff <= P_M;
                  end else begin
                     ma_ff    <= (dv_t == '0) ? '0 : '1;
                     phase_ff <= P_L;
                  end
               end else begin
                  r_ff     <= {4'b0000, dv_d[PSumW-1:4]};
                  den_ff   <= dv_t;
                  low_ff   <= {dv_d[3:0], 12'h000};
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               r_ff     <= r_in;
               low_ff   <= {low_ff[Q12W-2:0], 1'b0};
               q_ff     <= q_in;
               dstep_ff <= dstep_ff + 4'd1;
               if (dstep_ff == 4'd15) begin
                  unique case (phase_ff)
                     P_E: begin
                        ea_ff    <= q_in;
                        phase_ff <= P_M;
                        state_ff <= B_PREP;
                     end
                     P_M: begin
                        ma_ff    <= q_in;
                        phase_ff <= P_L;
                        state_ff <= B_PREP;
                     end
                     default: begin
                        lvl_ff   <= {1'b0, q_in};
                        state_ff <= B_OUT;
                     end
                  endcase
               end
            end
            B_OUT: begin
               // hold until the result register is free, then clear the event
               if (rsp_load) begin
                  rsp_ea_ff    <= ea_ff;
                  rsp_ma_ff    <= ma_ff;
                  rsp_lvl_ff   <= lvl_ff;
                  rsp_alert_ff <= lvl_ff > cfg.alert_level;
                  te_ff        <= '0;
                  re_ff        <= '0;
                  tp_ff        <= '0;
                  rp_ff        <= '0;
                  tcnt_ff      <= '0;
                  rcnt_ff      <= '0;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/truth_vs_reco_sum_anomaly_core.sv
// Top level of the truth versus reco sum anomaly monitor.
//
// Particles (op 0 truth, 1 reco) and end-of-event marks (op 2) enter on req_chan; op 3 is
// dropped. The front holds one particle at a time: it accepts it, makes four passes of its
// shared squaring multiplier, then hands it over into a two-entry queue, stalling while
// the queue is full; an end mark skips the multiplier. The back settles a particle as it
// pops it, or runs the 24-step square-root loop when its momentum passes the threshold,
// so that loop sets the sustained rate. A reporting end of event runs up to three 16-step
// divisions on one shared divider (a zero or saturated ratio skips its division), then the
// result is held in an output register until transferred on rsp_chan; further items keep
// flowing in until the queue fills. Registers are written through csr_we / csr_index /
// csr_wdata; the user must write only while the block is idle, which it does not enforce.
module truth_vs_reco_sum_anomaly_core #(
   parameter int MAX_PARTICLES = tvrs_pkg::DefMaxParticles
) (
   input  logic                           clock,
   input  logic                           reset,
   tvrs_req_if.sink                       req_chan,
   tvrs_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [tvrs_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [tvrs_pkg::CsrDataW-1:0]  csr_wdata
);
   import tvrs_pkg::*;

   tvrs_cfg_type  cfg_ff;
   tvrs_item_type push_item, pop_item;
   logic          push_valid, q_full, q_empty, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.energy_cut      <= '0;
         cfg_ff.mom_cut         <= '0;
         cfg_ff.max_anomaly     <= MAX_ANOM_RESET;
         cfg_ff.report_interval <= INTERVAL_RESET;
         cfg_ff.alert_level     <= ALERT_LVL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENERGY_THR: cfg_ff.energy_cut      <= csr_wdata[EnergyW-1:0];
            CSR_MOM_THR:    cfg_ff.mom_cut         <= csr_wdata[MomThrW-1:0];
            CSR_MAX_ANOM:   cfg_ff.max_anomaly     <= csr_wdata[Q12W-1:0];
            CSR_INTERVAL:   cfg_ff.report_interval <= csr_wdata[IntervW-1:0];
            CSR_ALERT_LVL:  cfg_ff.alert_level     <= csr_wdata[LevelW-1:0];
            default: ;
         endcase
      end
   end

   tvrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_full  (q_full)
   );

   tvrs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push_valid),
      .wdata (push_item),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (pop_item),
      .empty (q_empty)
   );

   tvrs_back #(.MAX_PARTICLES(MAX_PARTICLES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (pop_item),
      .item_valid (!q_empty),
      .pop        (q_pop),
      .rsp_chan   (rsp_chan)
   );

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.anomaly_level <= LEVEL_ONE)
      else $error("anomaly level above one");

   a_alert_match: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.alert == (rsp_chan.anomaly_level > cfg_ff.alert_level)))
      else $error("alert does not match level");

   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.op == OP_TRUTH || req_chan.op == OP_RECO))
      |=> !req_chan.ready)
      else $error("front took a particle while squaring");

endmodule

FILE: verif/truth_vs_reco_sum_anomaly_core_tb.sv
// Self-checking testbench for the truth versus reco sum anomaly monitor.
`timescale 1ns / 1ps

module truth_vs_reco_sum_anomaly_core_tb;
   import tvrs_pkg::*;

   localparam int MaxParts   = DefMaxParticles;
   localparam int SettleCyc  = 200;
   localparam int WatchLimit = 5000;
   localparam int HoldCyc    = 400;

   typedef struct {
      tvrs_op_type op;
      bit [23:0]   energy;
      bit [23:0]   px, py, pz;
   } particle_type;

   typedef struct {
      bit [15:0] e_anom;
      bit [15:0] p_anom;
      bit [16:0] level;
      bit        alert;
   } anomaly_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   tvrs_req_if req_chan ();
   tvrs_rsp_if rsp_chan ();

   truth_vs_reco_sum_anomaly_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   particle_type pending_parts[$];
   anomaly_type  anomaly_expected[$];
   particle_type on_wire;
   bit        send_hold = 1'b0;
   bit        idle_en   = 1'b1;
   int        hold_req  = 0;
   int        hold_seen = 0;
   int        hold_cnt  = 0;
   int        stall_cyc = 0;
   int        fail_cnt  = 0;

   // predictor copy of configuration and state
   bit [23:0] m_e_thr;
   bit [24:0] m_p_thr;
   bit [15:0] m_max_anom;
   bit [15:0] m_interval;
   bit [16:0] m_alert_lvl;
   bit [33:0] m_truth_e, m_reco_e;
   bit [34:0] m_truth_p, m_reco_p;
   bit [15:0] m_events;
   int        m_truth_n, m_reco_n;

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, pw;
      root = 0;
      pw = 64'd1 << 62;
      while (pw > n) pw >>= 2;
      while (pw != 0) begin
         if (n >= root + pw) begin
            n -= root + pw;
            root = (root >> 1) + pw;
         end else begin
            root >>= 1;
         end
         pw >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned mag24(bit [23:0] v);
      if (v[23]) return 64'h1000000 - v;
      return v;
   endfunction

   function automatic longint unsigned rel_diff(longint unsigned t, longint unsigned r);
      longint unsigned d, q;
      if (t == 0) return 0;
      d = (r > t) ? r - t : t - r;
      q = (d << 12) / t;
      return (q > 65535) ? 65535 : q;
   endfunction

   function automatic longint unsigned sat(longint unsigned s, longint unsigned cap);
      return (s > cap) ? cap : s;
   endfunction

   function automatic void clear_sums();
      m_truth_e = 0; m_reco_e = 0; m_truth_p = 0; m_reco_p = 0;
      m_truth_n = 0; m_reco_n = 0;
   endfunction

   function automatic void predict_anomaly(particle_type it);
      longint unsigned sq, mag, thr, intv, ea, ma, s, lim, lvl;
      bit e_ok, p_ok;
      anomaly_type res;
      case (it.op) inside
         OP_TRUTH, OP_RECO: begin
            sq = mag24(it.px) * mag24(it.px) + mag24(it.py) * mag24(it.py)
                 + mag24(it.pz) * mag24(it.pz);
            thr = m_p_thr;
            e_ok = it.energy > m_e_thr;
            p_ok = sq > thr * thr;
            mag = int_sqrt(sq);
            if (it.op == OP_TRUTH) begin
               if (m_truth_n < MaxParts) begin
                  m_truth_n++;
                  if (e_ok) m_truth_e = 34'(sat(64'(m_truth_e) + it.energy, 64'h3_FFFF_FFFF));
                  if (p_ok) m_truth_p = 35'(sat(64'(m_truth_p) + mag, 64'h7_FFFF_FFFF));
               end
            end else if (m_reco_n < MaxParts) begin
               m_reco_n++;
               if (e_ok) m_reco_e = 34'(sat(64'(m_reco_e) + it.energy, 64'h3_FFFF_FFFF));
               if (p_ok) m_reco_p = 35'(sat(64'(m_reco_p) + mag, 64'h7_FFFF_FFFF));
            end
         end
         OP_END: begin
            intv = (m_interval == 0) ? 1 : m_interval;
            m_events = m_events + 1'b1;
            if (m_events >= intv) begin
               m_events = 0;
               ea = rel_diff(m_truth_e, m_reco_e);
               ma = rel_diff(m_truth_p, m_reco_p);
               s = ea + ma;
               lim = 2 * ((m_max_anom == 0) ? 1 : m_max_anom);
               if (s > lim) s = lim;
               lvl = (s * 65536) / lim;
               res.e_anom = 16'(ea);
               res.p_anom = 16'(ma);
               res.level = 17'(lvl);
               res.alert = lvl > m_alert_lvl;
               anomaly_expected.push_back(res);
            end
            clear_sums();
         end
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         m_events = 0;
         clear_sums();
      end else begin
         if (req_chan.valid && req_chan.ready) predict_anomaly(on_wire);
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_parts.size() != 0 && !send_hold
                && !(idle_en && $urandom_range(99) < 10)) begin
               on_wire = pending_parts.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.op <= on_wire.op;
               req_chan.particle_energy <= on_wire.energy;
               req_chan.mom_x <= on_wire.px;
               req_chan.mom_y <= on_wire.py;
               req_chan.mom_z <= on_wire.pz;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      anomaly_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (anomaly_expected.size() == 0) begin
               $display("%0t: unexpected result e=%0d p=%0d lvl=%0d alert=%0d", $realtime,
                        rsp_chan.energy_dev, rsp_chan.mom_dev,
                        rsp_chan.anomaly_level, rsp_chan.alert);
               fail_cnt++;
            end else begin
               want = anomaly_expected.pop_front();
               if (rsp_chan.energy_dev !== want.e_anom
                   || rsp_chan.mom_dev !== want.p_anom
                   || rsp_chan.anomaly_level !== want.level
                   || rsp_chan.alert !== want.alert) begin
                  $display("%0t: expected e=%0d p=%0d lvl=%0d alert=%0d, %s", $realtime,
                           want.e_anom, want.p_anom, want.level, want.alert, "got");
                  $display("%0t:    got e=%0d p=%0d lvl=%0d alert=%0d", $realtime,
                           rsp_chan.energy_dev, rsp_chan.mom_dev,
                           rsp_chan.anomaly_level, rsp_chan.alert);
                  fail_cnt++;
               end
            end
         end
         if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt <= HoldCyc;
            rsp_chan.ready <= 1'b0;
         end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !(idle_en && $urandom_range(99) < 10);
         end
      end
   end

   // watchdog on cycles without any transfer while work is outstanding
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (pending_parts.size() == 0 && !req_chan.valid && anomaly_expected.size() == 0))
         stall_cyc <= 0;
      else if (stall_cyc >= WatchLimit) begin
         $display("truth_vs_reco_sum_anomaly_core: mismatch");
         $finish;
      end else
         stall_cyc <= stall_cyc + 1;
   end

   function automatic bit [23:0] pick_mom();
      case ($urandom_range(7))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'h000000;
         3: return 24'($urandom);
         default: return 24'($signed($urandom_range(4000)) - 2000);
      endcase
   endfunction

   function automatic bit [23:0] pick_energy();
      case ($urandom_range(7))
         0: return 24'hFFFFFF;
         1: return 24'h000000;
         2: return 24'($urandom);
         default: return 24'($urandom_range(100000));
      endcase
   endfunction

   task automatic add_part(tvrs_op_type op, bit [23:0] e, bit [23:0] x, bit [23:0] y,
                           bit [23:0] z);
      particle_type p;
      p.op = op; p.energy = e; p.px = x; p.py = y; p.pz = z;
      pending_parts.push_back(p);
   endtask

   task automatic end_event();
      add_part(OP_END, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
   endtask

   // truth particles and reco copies with perturbation, plus some noise
   task automatic random_event();
      particle_type tr[$];
      particle_type p;
      int n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         p.op = OP_TRUTH; p.energy = pick_energy();
         p.px = pick_mom(); p.py = pick_mom(); p.pz = pick_mom();
         tr.push_back(p);
         pending_parts.push_back(p);
      end
      foreach (tr[i]) begin
         p = tr[i];
         p.op = OP_RECO;
         if ($urandom_range(3) != 0) begin
            p.energy = p.energy + 24'($signed($urandom_range(200)) - 100);
            p.px = p.px + 24'($signed($urandom_range(200)) - 100);
         end else begin
            p.energy = pick_energy(); p.px = pick_mom();
         end
         if ($urandom_range(5) != 0) pending_parts.push_back(p);
      end
      if ($urandom_range(9) == 0)
         add_part(OP_NONE, pick_energy(), pick_mom(), pick_mom(), pick_mom());
      end_event();
   endtask

   task automatic wait_idle();
      while (pending_parts.size() != 0 || req_chan.valid || anomaly_expected.size() != 0)
         @(posedge clock);
      repeat (SettleCyc) @(posedge clock);
   endtask

   task automatic configure(bit [23:0] e_thr, bit [24:0] p_thr, bit [15:0] max_a,
                            bit [15:0] intv, bit [16:0] alert_l);
      bit [24:0] vals[5];
      vals = '{25'(e_thr), p_thr, 25'(max_a), 25'(intv), 25'(alert_l)};
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= CsrIdxW'(i);
         csr_wdata <= vals[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      m_e_thr = e_thr; m_p_thr = p_thr; m_max_anom = max_a;
      m_interval = intv; m_alert_lvl = alert_l;
   endtask

   initial begin
      csr_we = 1'b0;
      csr_index = CSR_ENERGY_THR;
      csr_wdata = '0;
      m_e_thr = 0; m_p_thr = 0; m_max_anom = MAX_ANOM_RESET;
      m_interval = INTERVAL_RESET; m_alert_lvl = ALERT_LVL_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, extremes, zero truth, unused op
      add_part(OP_TRUTH, 24'hFFFFFF, 24'h800000, 24'h800000, 24'h800000);
      add_part(OP_RECO, 24'h000000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      end_event();
      add_part(OP_RECO, 24'd5000, 24'd300, 24'hFFFF00, 24'd7);
      end_event();
      add_part(OP_TRUTH, 24'd1000, 24'd100, 24'd0, 24'd0);
      add_part(OP_RECO, 24'd1000, 24'd100, 24'd0, 24'd0);
      add_part(OP_NONE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      end_event();
      add_part(OP_TRUTH, 24'd1000, 24'd3, 24'd4, 24'd0);
      add_part(OP_RECO, 24'd1100, 24'd6, 24'd8, 24'd0);
      end_event();
      end_event();
      wait_idle();

      // threshold edges: value equal to threshold is dropped; zero divisor and interval
      configure(24'd1000, 25'd5, 16'd0, 16'd0, 17'd0);
      add_part(OP_TRUTH, 24'd1000, 24'd3, 24'd4, 24'd0);
      add_part(OP_TRUTH, 24'd1001, 24'd3, 24'd4, 24'd1);
      add_part(OP_RECO, 24'd2000, 24'd30, 24'd4, 24'd0);
      end_event();
      wait_idle();

      // interval lowered below the count reports on the next end
      configure(24'd0, 25'd0, 16'd4096, 16'd5, 17'd6554);
      repeat (3) random_event();
      wait_idle();
      configure(24'd0, 25'd0, 16'hFFFF, 16'd2, 17'd65536);
      random_event();
      random_event();
      wait_idle();

      // random phases across several settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: configure(24'd0, 25'd0, 16'd4096, 16'd1, 17'd6554);
            1: configure(24'hFFFFFF, 25'h1FFFFFF, 16'd1, 16'd1, 17'd0);
            2: configure(24'($urandom_range(50000)), 25'($urandom_range(3000)),
                         16'($urandom_range(1, 65535)), 16'd2, 17'($urandom_range(65536)));
            3: configure(24'd10, 25'd10, 16'hFFFF, 16'hFFFF, 17'd65536);
            4: configure(24'($urandom), 25'($urandom), 16'($urandom), 16'd1,
                         17'($urandom_range(65536)));
            default: configure(24'd0, 25'd100, 16'd8192, 16'd1, 17'd20000);
         endcase
         idle_en = (ph != 5);
         if (ph == 3) begin
            repeat (4) random_event();
         end else begin
            repeat (4) random_event();
            if (ph == 0) hold_req = hold_req + 1;
            repeat (4) random_event();
            if (ph == 4) begin
               send_hold = 1'b1;
               while (anomaly_expected.size() != 0 || req_chan.valid) @(posedge clock);
               send_hold = 1'b0;
               repeat (4) random_event();
            end
         end
         wait_idle();
      end

      if (fail_cnt == 0 && anomaly_expected.size() == 0)
         $display("truth_vs_reco_sum_anomaly_core: match");
      else
         $display("truth_vs_reco_sum_anomaly_core: mismatch");
      $finish;
   end

endmodule

FILE: files.f
rtl/tvrs_pkg.sv
rtl/tvrs_ifs.sv
rtl/tvrs_front.sv
rtl/tvrs_queue.sv
rtl/tvrs_back.sv
rtl/truth_vs_reco_sum_anomaly_core.sv
verif/truth_vs_reco_sum_anomaly_core_tb.sv
